// ----- rtl/plc_pkg.sv -----
`default_nettype none
package plc_pkg;

  // field widths of the words on the channels
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 8;

  // default list capacity
  localparam int DEPTH_DEF = 128;

  // position field of the cell command bus, wide enough for capacities up to 8191
  localparam int CMD_POS_W = 13;

  // cells per first-level group of the read tree
  localparam int GROUP = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_FIRST = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_LAST  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE       = 3'd3;
  localparam logic [OP_W-1:0] OP_READ         = 3'd4;
  localparam logic [OP_W-1:0] OP_REPLACE      = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // action broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_REPLACE
  } cmd_act_t;

  typedef struct packed {
    cmd_act_t                   act;
    logic [CMD_POS_W-1:0]       pos;
    logic signed [DATA_W-1:0]   val;
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_APPLY
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/plc_req_if.sv -----
`default_nettype none
interface plc_req_if;
  logic                             valid;
  logic                             ready;
  logic [plc_pkg::OP_W-1:0]         operation;
  logic [plc_pkg::POS_W-1:0]        position;
  logic signed [plc_pkg::DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface
`default_nettype wire

// ----- rtl/plc_rsp_if.sv -----
`default_nettype none
interface plc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [plc_pkg::DATA_W-1:0] read_value;
  logic [plc_pkg::STAT_W-1:0]        status;
  logic [plc_pkg::LEN_W-1:0]         length;
  logic                              empty_res;
  logic                              full_res;

  modport source (output valid, read_value, status, length, empty_res, full_res,
                  input ready);
  modport sink   (input valid, read_value, status, length, empty_res, full_res,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/plc_cell.sv -----
`default_nettype none
module plc_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  plc_pkg::cmd_t                     cmd,
  input  logic signed [plc_pkg::DATA_W-1:0] left,
  input  logic signed [plc_pkg::DATA_W-1:0] right,
  output logic signed [plc_pkg::DATA_W-1:0] q,
  output logic signed [plc_pkg::DATA_W-1:0] tap
);
  import plc_pkg::*;

  localparam logic [CMD_POS_W-1:0] ME = CMD_POS_W'(IDX);

  // entry update: shift from a neighbour or take the new word
  always_ff @(posedge clk) begin
    case (cmd.act)
      CMD_INSERT: begin
        if (ME > cmd.pos) begin
          q <= left;
        end else if (ME == cmd.pos) begin
          q <= cmd.val;
        end
      end
      CMD_DELETE: begin
        if (ME >= cmd.pos) begin
          q <= right;
        end
      end
      CMD_REPLACE: begin
        if (ME == cmd.pos) begin
          q <= cmd.val;
        end
      end
      default: begin
      end
    endcase
  end

  // only the addressed cell drives its tap
  assign tap = (ME == cmd.pos) ? q : '0;

endmodule
`default_nettype wire

// ----- rtl/plc_gather.sv -----
`default_nettype none
module plc_gather #(
  parameter int DEPTH = plc_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic signed [plc_pkg::DATA_W-1:0] taps [DEPTH],
  output logic signed [plc_pkg::DATA_W-1:0] word
);
  import plc_pkg::*;

  localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

  logic [DATA_W-1:0] grp_next [NGROUP];
  logic [DATA_W-1:0] grp      [NGROUP];
  logic [DATA_W-1:0] all_or;

  // first level: or of the taps within each group
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          grp_next[g] = grp_next[g] | taps[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp[g] <= grp_next[g];
    end
  end

  // second level: or of the registered groups
  always_comb begin
    all_or = '0;
    for (int g = 0; g < NGROUP; g++) begin
      all_or = all_or | grp[g];
    end
  end

  assign word = all_or;

endmodule
`default_nettype wire

// ----- rtl/positional_array_list.sv -----
`default_nettype none
// channel | dir | words carried
// --------+-----+------------------------------------------------------------
// req     | in  | operation, position, value
// rsp     | out | read_value, status, length, empty_res, full_res
//
// each word goes through accept, gather of the addressed entry through
// the registered or tree of the cell row, then apply, where every cell shifts
// or loads in parallel. req.ready is high only while the sequencer idles.
// a finished word waits in the output register; apply stalls while it is
// still held. rst clears the count and the handshake; entries need no reset.
module positional_array_list #(
  parameter int DEPTH = plc_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  plc_req_if.sink         req,
  plc_rsp_if.source       rsp
);
  import plc_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         pos;
  logic signed [DATA_W-1:0] val;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  cmd_act_t                 act;
  logic [CMD_POS_W-1:0]     at_pos;
  logic [STAT_W-1:0]        stat;
  logic signed [DATA_W-1:0] rd;
  logic                     full;
  logic                     out_free;
  logic                     apply_go;
  cmd_t                     cmd;

  logic signed [DATA_W-1:0] cells [DEPTH];
  logic signed [DATA_W-1:0] taps  [DEPTH];
  logic signed [DATA_W-1:0] gathered;

  assign out_free = !rsp.valid || rsp.ready;
  assign apply_go = (state == S_APPLY) && out_free;
  assign full     = 32'(count) >= 32'(DEPTH);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req.valid) state_next = S_GATHER;
      S_GATHER: state_next = S_APPLY;
      S_APPLY:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the request word
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= req.operation;
      pos <= req.position;
      val <= req.value;
    end
  end

  // operation decode against the current count
  always_comb begin
    act        = CMD_HOLD;
    at_pos     = CMD_POS_W'(pos);
    stat       = STAT_OK;
    rd         = '0;
    count_next = count;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          stat = STAT_FULL;
        end else if (32'(pos) > 32'(count)) begin
          stat = STAT_RANGE;
        end else begin
          act        = CMD_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      OP_INSERT_FIRST: begin
        at_pos = '0;
        if (full) begin
          stat = STAT_FULL;
        end else begin
          act        = CMD_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      OP_INSERT_LAST: begin
        at_pos = CMD_POS_W'(count);
        if (full) begin
          stat = STAT_FULL;
        end else begin
          act        = CMD_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (32'(pos) >= 32'(count)) begin
          stat = STAT_RANGE;
        end else begin
          act        = CMD_DELETE;
          rd         = gathered;
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (32'(pos) >= 32'(count)) begin
          stat = STAT_RANGE;
        end else begin
          rd = gathered;
        end
      end
      OP_REPLACE: begin
        if (32'(pos) >= 32'(count)) begin
          stat = STAT_RANGE;
        end else begin
          act = CMD_REPLACE;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // broadcast to the cell row
  always_comb begin
    cmd.act = apply_go ? act : CMD_HOLD;
    cmd.pos = at_pos;
    cmd.val = val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // row of cells, each linked to its neighbours; the first sees zero on its left, the last itself on its right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] from_left;
    logic signed [DATA_W-1:0] from_right;
    if (i == 0) begin : g_first
      assign from_left = '0;
    end else begin : g_mid_l
      assign from_left = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign from_right = cells[i];
    end else begin : g_mid_r
      assign from_right = cells[i+1];
    end
    plc_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (from_left),
      .right (from_right),
      .q     (cells[i]),
      .tap   (taps[i])
    );
  end

  plc_gather #(.DEPTH(DEPTH)) u_gather (
    .clk  (clk),
    .taps (taps),
    .word (gathered)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (apply_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp.read_value <= rd;
      rsp.status     <= stat;
      rsp.length     <= LEN_W'(count_next);
      rsp.empty_res  <= (count_next == '0);
      rsp.full_res   <= (32'(count_next) >= 32'(DEPTH));
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  import plc_pkg::*;

  localparam int LIST_DEPTH = 128;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;
    logic                     empty_res;
    logic                     full_res;
  } result_t;

  typedef enum {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} op_bias_t;
  typedef enum {SEG_GROW, SEG_FILL, SEG_MIXED, SEG_DRAIN, SEG_SHRINK} seg_kind_t;

  // shadow of the list and the queue of results still owed by the block
  class list_scoreboard;
    logic signed [DATA_W-1:0] cells [LIST_DEPTH];
    int unsigned held;
    result_t owed_q[$];
    int unsigned errors;

    function new();
      held = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      errors++;
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    // shift later entries up and load the new value
    function void open_slot(int unsigned at, logic signed [DATA_W-1:0] val);
      for (int unsigned i = held; i > at; i--) cells[i] = cells[i-1];
      cells[at] = val;
      held++;
    endfunction

    // work out the result of an accepted word and update the shadow list
    task note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                   logic signed [DATA_W-1:0] val);
      result_t r;
      int unsigned p;
      bit full;
      r = '0;
      p = pos;
      full = (held >= LIST_DEPTH);
      r.status = STAT_OK;
      case (op)
        OP_INSERT: begin
          if (full) r.status = STAT_FULL;
          else if (p > held) r.status = STAT_RANGE;
          else open_slot(p, val);
        end
        OP_INSERT_FIRST: begin
          if (full) r.status = STAT_FULL;
          else open_slot(0, val);
        end
        OP_INSERT_LAST: begin
          if (full) r.status = STAT_FULL;
          else open_slot(held, val);
        end
        OP_DELETE: begin
          if (p >= held) begin
            r.status = STAT_RANGE;
          end else begin
            r.read_value = cells[p];
            for (int unsigned i = p + 1; i < held; i++) cells[i-1] = cells[i];
            held--;
          end
        end
        OP_READ: begin
          if (p >= held) r.status = STAT_RANGE;
          else r.read_value = cells[p];
        end
        OP_REPLACE: begin
          if (p >= held) r.status = STAT_RANGE;
          else cells[p] = val;
        end
        OP_CLEAR: held = 0;
        default: ;
      endcase
      r.length = held[LEN_W-1:0];
      r.empty_res = (held == 0);
      r.full_res = (held >= LIST_DEPTH);
      owed_q.push_back(r);
    endtask

    // compare a result word against the oldest owed result
    task check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        report("unexpected word", got.read_value, '0);
      end else begin
        want = owed_q.pop_front();
        if (got.read_value !== want.read_value)
          report("read_value", got.read_value, want.read_value);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.length !== want.length) report("length", got.length, want.length);
        if (got.empty_res !== want.empty_res)
          report("empty_res", got.empty_res, want.empty_res);
        if (got.full_res !== want.full_res)
          report("full_res", got.full_res, want.full_res);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  plc_req_if req();
  plc_rsp_if rsp();

  positional_array_list #(.DEPTH(LIST_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  list_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int items;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver side stalls at random
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.read_value, rsp.status, rsp.length, rsp.empty_res, rsp.full_res});
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 61; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 61; end
      default: begin send_idle_pct = 35; stall_pct = 35; end
    endcase
  endtask

  // offer one word, holding it until the block takes it
  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.position <= pos;
    req.value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items++;
    sb.note_word(op, pos, val);
  endtask

  function automatic logic [OP_W-1:0] pick_op(op_bias_t bias);
    int r;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW: begin
        if (r < 70) return OP_W'($urandom_range(0, 2));
        if (r < 80) return OP_READ;
        if (r < 88) return OP_REPLACE;
        if (r < 96) return OP_DELETE;
        if (r < 99) return OP_UNUSED;
        return OP_CLEAR;
      end
      BIAS_SHRINK: begin
        if (r < 60) return OP_DELETE;
        if (r < 75) return OP_READ;
        if (r < 85) return OP_REPLACE;
        if (r < 95) return OP_W'($urandom_range(0, 2));
        if (r < 98) return OP_UNUSED;
        return OP_CLEAR;
      end
      default: begin
        if (r < 3) return OP_CLEAR;
        if (r < 8) return OP_UNUSED;
        return OP_W'($urandom_range(0, 5));
      end
    endcase
  endfunction

  // mostly positions inside the list, now and then anything the field holds
  function automatic logic [POS_W-1:0] pick_position(logic [OP_W-1:0] op);
    int unsigned h;
    h = sb.held;
    if ($urandom_range(0, 99) >= 85) return POS_W'($urandom_range(0, 127));
    if (op == OP_INSERT) return POS_W'((h > 127) ? 127 : $urandom_range(0, h));
    if ((op == OP_DELETE || op == OP_READ || op == OP_REPLACE) && h > 0)
      return POS_W'($urandom_range(0, h - 1));
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 39))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word(op_bias_t bias);
    logic [OP_W-1:0] op;
    op = pick_op(bias);
    send_word(op, pick_position(op), pick_value());
  endtask

  task automatic run_segment(seg_kind_t kind);
    logic [OP_W-1:0] op;
    case (kind)
      SEG_GROW: repeat (100) random_word(BIAS_GROW);
      SEG_SHRINK: repeat (100) random_word(BIAS_SHRINK);
      SEG_MIXED: repeat (100) random_word(BIAS_MIXED);
      SEG_FILL: begin
        // fill to capacity, then push against the full list
        while (sb.held < LIST_DEPTH) begin
          op = OP_W'($urandom_range(0, 2));
          send_word(op, pick_position(op), pick_value());
        end
        send_word(OP_INSERT, 7'd127, pick_value());
        send_word(OP_INSERT, 7'd0, pick_value());
        send_word(OP_INSERT_FIRST, 7'd0, pick_value());
        send_word(OP_INSERT_LAST, 7'd127, pick_value());
        send_word(OP_READ, 7'd127, '0);
        send_word(OP_REPLACE, 7'd127, pick_value());
        send_word(OP_READ, 7'd127, '0);
        send_word(OP_DELETE, 7'd127, '0);
        send_word(OP_INSERT, 7'd127, pick_value());
        send_word(OP_DELETE, 7'd0, '0);
      end
      default: begin
        // drain to empty, then probe the empty list
        while (sb.held > 0) send_word(OP_DELETE, pick_position(OP_DELETE), '0);
        send_word(OP_READ, 7'd0, '0);
        send_word(OP_DELETE, 7'd0, '0);
        send_word(OP_REPLACE, 7'd0, pick_value());
        send_word(OP_INSERT, 7'd1, pick_value());
        send_word(OP_CLEAR, POS_W'($urandom_range(0, 127)), pick_value());
      end
    endcase
  endtask

  initial begin
    int seg;
    sb = new();
    items = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_INSERT;
    req.position <= '0;
    req.value <= '0;
    set_idling(0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, shifts, unused code, clear
    send_word(OP_READ, 7'd0, '0);
    send_word(OP_DELETE, 7'd0, '0);
    send_word(OP_REPLACE, 7'd0, 32'sh1111_1111);
    send_word(OP_INSERT, 7'd1, 32'sh2222_2222);
    send_word(OP_INSERT, 7'd0, 32'sh7FFF_FFFF);
    send_word(OP_INSERT_FIRST, 7'd0, 32'sh8000_0000);
    send_word(OP_INSERT_LAST, 7'd0, '0);
    send_word(OP_INSERT, 7'd3, -32'sd1);
    send_word(OP_INSERT, 7'd5, 32'sh3333_3333);
    send_word(OP_INSERT, 7'd127, 32'sh5555_5555);
    send_word(OP_READ, 7'd0, '0);
    send_word(OP_READ, 7'd3, '0);
    send_word(OP_READ, 7'd4, '0);
    send_word(OP_REPLACE, 7'd1, 32'shAAAA_AAAA);
    send_word(OP_READ, 7'd1, '0);
    send_word(OP_INSERT, 7'd2, 32'sh1234_5678);
    send_word(OP_DELETE, 7'd4, '0);
    send_word(OP_DELETE, 7'd1, '0);
    send_word(OP_DELETE, 7'd0, '0);
    send_word(OP_UNUSED, 7'd127, -32'sd1);
    send_word(OP_CLEAR, 7'd0, '0);
    send_word(OP_READ, 7'd0, '0);
    send_word(OP_INSERT_LAST, 7'd0, 32'sd1);
    send_word(OP_READ, 7'd0, '0);
    send_word(OP_DELETE, 7'd127, '0);

    // random segments under rotating idling
    seg = 0;
    while (items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      set_idling(seg % 4);
      run_segment(seg_kind_t'(seg % 5));
      if (seg == 2) begin
        // hold off until every owed result has come back
        req.valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      seg++;
    end

    // drain and let the block settle
    req.valid <= 1'b0;
    set_idling(0);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/plc_pkg.sv
rtl/plc_req_if.sv
rtl/plc_rsp_if.sv
rtl/plc_cell.sv
rtl/plc_gather.sv
rtl/positional_array_list.sv
tb/sv/tb_top.sv
